// ===== rtl/core/bis_pkg.sv =====
`timescale 1ns / 1ps

package bis_pkg;

  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int STAT_W    = 3;
  localparam int COUNT_W   = 5;
  localparam int DEPTH_DEF = 16;
  localparam int CAP_RST   = 16;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 2'd0;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic              capture;
    logic              do_ins;
    logic              do_rem;
    logic              load_out;
    logic [STAT_W-1:0] status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cmd;
    logic found;
    logic full;
  } dp_stat_t;

endpackage

// ===== rtl/core/bounded_integer_set_top.sv =====
`timescale 1ns / 1ps
// At accept the request is compared against the entries into the match register; when the
// update is applied, the entries, the result register and out_valid load together. Requests
// are taken one at a time: the next is taken once the update is applied, even while a result
// still waits; the update stalls only if the result is not taken. Entries compare in parallel.
// Reset (rst_n, synchronous): set empty, capacity 16; entries are not cleared.

module bounded_integer_set_top import bis_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic [COUNT_W-1:0]       out_count,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_W-1:0]    paddr,
  input  logic [CFG_DATA_W-1:0]    pwdata,
  output logic [CFG_DATA_W-1:0]    prdata,
  output logic                     pready
);

  logic [CAP_W-1:0] capacity_r;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_W'(CAP_RST);
    end else if (psel && penable && pwrite && pready && (paddr == REG_CAPACITY)) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr == REG_CAPACITY) ? CFG_DATA_W'(capacity_r) : '0;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .capacity   (capacity_r),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_status),
    .out_count  (out_count)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_ABSENT))
    else $error("illegal status code");

  a_no_double_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_ins && cmd.do_rem))
    else $error("insert and remove in one cycle");

  a_result_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("update without result");

endmodule

// ===== rtl/core/bis_dp.sv =====
`timescale 1ns / 1ps

module bis_dp import bis_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_cmd,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic [CAP_W-1:0]         capacity,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic [STAT_W-1:0]        out_status,
  output logic [COUNT_W-1:0]       out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic signed [VAL_W-1:0] ent_r [DEPTH];
  logic [DEPTH-1:0]        match_r;
  logic                    cmd_r;
  logic signed [VAL_W-1:0] value_r;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [STAT_W-1:0]       status_r;
  logic [COUNT_W-1:0]      count_r;
  logic [IDX_W-1:0]        slot;
  logic                    full;

  // set elements are distinct, so at most one match bit is high
  always_comb begin
    slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_r[i]) begin
        slot = slot | IDX_W'(i);
      end
    end
  end

  assign full = (LIM_W'(fill_r) >= LIM_W'(DEPTH)) || (LIM_W'(fill_r) >= LIM_W'(capacity));

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.do_ins) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (cmd.do_rem) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // compare the incoming request against every live entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
      for (int i = 0; i < DEPTH; i++) begin
        match_r[i] <= (ent_r[i] == in_value) && (CNT_W'(i) < fill_r);
      end
    end
  end

  // append at the tail, or close the gap above the removed slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.do_ins && (fill_r == CNT_W'(i))) begin
        ent_r[i] <= value_r;
      end else if (cmd.do_rem && (i + 1 < DEPTH) && (IDX_W'(i) >= slot)) begin
        ent_r[i] <= ent_r[(i + 1 < DEPTH) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r <= cmd.status;
      count_r  <= COUNT_W'(fill_nxt);
    end
  end

  assign stat.cmd   = cmd_r;
  assign stat.found = |match_r;
  assign stat.full  = full;

  assign out_status = status_r;
  assign out_count  = count_r;

endmodule

// ===== rtl/core/bis_ctrl.sv =====
`timescale 1ns / 1ps

module bis_ctrl import bis_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic apply;

  assign in_ready = (state_r == S_IDLE);
  // hold the update until the result register is free
  assign apply = (state_r == S_UPD) && (!out_valid_r || out_ready);

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_valid && in_ready;
    cmd.load_out = apply;
    if (stat.cmd == CMD_INSERT) begin
      if (stat.found) begin
        cmd.status = ST_PRESENT;
      end else if (stat.full) begin
        cmd.status = ST_FULL;
      end else begin
        cmd.status = ST_INSERTED;
        cmd.do_ins = apply;
      end
    end else begin
      if (stat.found) begin
        cmd.status = ST_REMOVED;
        cmd.do_rem = apply;
      end else begin
        cmd.status = ST_ABSENT;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (apply) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
